### rtl/core/magnetic_heading_from_xy_defines.svh
// assertion macros shared by the heading block
`ifndef MAGNETIC_HEADING_FROM_XY_DEFINES_SVH
`define MAGNETIC_HEADING_FROM_XY_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication check
`define MHXY_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication check
`define MHXY_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define MHXY_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MHXY_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/core/mhxy_pkg.sv
// shared types, constants and the arctangent table of the heading block
`timescale 1ns / 1ps

package mhxy_pkg;

   // number of cordic cells in the chain (12..24)
   localparam int CORDIC_ITERS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int SHIFT_W      = 5;

   // datapath widths: 17 bit magnitude, 8 guard bits, cordic growth
   localparam int IN_W       = 16;
   localparam int GUARD_BITS = 8;
   localparam int DATA_W     = 28;
   localparam int ANGLE_W    = 27;
   localparam int FRAC_BITS  = 16;
   localparam int WHOLE_W    = ANGLE_W - FRAC_BITS;
   localparam int DEG_W      = 9;
   localparam int HEAD_W     = 10;

   localparam logic signed [ANGLE_W-1:0] HALF_TURN_Q16 = 27'sd11796480;
   localparam logic [DEG_W-1:0] FULL_TURN    = 9'd360;
   localparam logic [DEG_W-1:0] OFFSET_RESET = 9'd75;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_HEADING_OFFSET = 1'b0;

   // atan(2^-i) in degrees, 16 fractional bits
   localparam logic signed [ANGLE_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
      27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379,
      27'sd117304,  27'sd58666,   27'sd29335,  27'sd14668,  27'sd7334,
      27'sd3667,    27'sd1833,    27'sd917,    27'sd458,    27'sd229,
      27'sd115,     27'sd57,      27'sd29,     27'sd14,     27'sd7,
      27'sd4,       27'sd2,       27'sd1,      27'sd0
   };

   // vector and angle handed from cell to cell
   typedef struct packed {
      logic                      zero;
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  y;
      logic signed [ANGLE_W-1:0] z;
   } cordic_data_type;

endpackage

### rtl/core/mhxy_prerot.sv
// input cell: half-plane fold, guard scaling and zero-vector detect
`timescale 1ns / 1ps

module mhxy_prerot (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   up_valid,
   input  logic signed [mhxy_pkg::IN_W-1:0]       up_x,
   input  logic signed [mhxy_pkg::IN_W-1:0]       up_y,
   output logic                                   up_ready,
   output logic                                   dn_valid,
   output mhxy_pkg::cordic_data_type              dn_data,
   input  logic                                   dn_ready
);

   logic                           valid_ff;
   logic                           valid_in;
   mhxy_pkg::cordic_data_type      data_ff;
   mhxy_pkg::cordic_data_type      data_in;
   logic signed [mhxy_pkg::DATA_W-1:0] x_ext;
   logic signed [mhxy_pkg::DATA_W-1:0] y_ext;
   logic signed [mhxy_pkg::DATA_W-1:0] x_fold;
   logic signed [mhxy_pkg::DATA_W-1:0] y_fold;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // fold the left half plane onto the right one, start angle at +-180
   always_comb begin
      x_ext = mhxy_pkg::DATA_W'(up_x);
      y_ext = mhxy_pkg::DATA_W'(up_y);
      data_in.zero = (up_x == '0) && (up_y == '0);
      if (up_x < 0) begin
         x_fold = -x_ext;
         y_fold = -y_ext;
         data_in.z = (up_y >= 0) ? mhxy_pkg::HALF_TURN_Q16 : -mhxy_pkg::HALF_TURN_Q16;
      end else begin
         x_fold = x_ext;
         y_fold = y_ext;
         data_in.z = '0;
      end
      data_in.x = {x_fold[mhxy_pkg::DATA_W-mhxy_pkg::GUARD_BITS-1:0],
                   {mhxy_pkg::GUARD_BITS{1'b0}}};
      data_in.y = {y_fold[mhxy_pkg::DATA_W-mhxy_pkg::GUARD_BITS-1:0],
                   {mhxy_pkg::GUARD_BITS{1'b0}}};
   end

   // cell registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

### rtl/core/mhxy_cell.sv
// one cordic vectoring cell: shift-add micro-rotation toward y = 0
`timescale 1ns / 1ps

module mhxy_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mhxy_pkg::SHIFT_W-1:0]        shift_amt,
   input  logic                                up_valid,
   input  mhxy_pkg::cordic_data_type           up_data,
   output logic                                up_ready,
   output logic                                dn_valid,
   output mhxy_pkg::cordic_data_type           dn_data,
   input  logic                                dn_ready
);

   logic                                valid_ff;
   logic                                valid_in;
   mhxy_pkg::cordic_data_type           data_ff;
   mhxy_pkg::cordic_data_type           data_in;
   logic signed [mhxy_pkg::DATA_W-1:0]  x_cur;
   logic signed [mhxy_pkg::DATA_W-1:0]  y_cur;
   logic signed [mhxy_pkg::DATA_W-1:0]  dx;
   logic signed [mhxy_pkg::DATA_W-1:0]  dy;
   logic signed [mhxy_pkg::ANGLE_W-1:0] z_cur;
   logic signed [mhxy_pkg::ANGLE_W-1:0] step_angle;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // micro-rotation, direction from the sign of y
   always_comb begin
      x_cur      = up_data.x;
      y_cur      = up_data.y;
      z_cur      = up_data.z;
      step_angle = mhxy_pkg::ATAN_TABLE[shift_amt];
      dx         = y_cur >>> shift_amt;
      dy         = x_cur >>> shift_amt;
      data_in.zero = up_data.zero;
      if (y_cur >= 0) begin
         data_in.x = x_cur + dx;
         data_in.y = y_cur - dy;
         data_in.z = z_cur + step_angle;
      end else begin
         data_in.x = x_cur - dx;
         data_in.y = y_cur + dy;
         data_in.z = z_cur - step_angle;
      end
   end

   // cell registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

### rtl/core/mhxy_post.sv
// output cell: truncate to whole degrees, wrap, subtract offset, hold result
`timescale 1ns / 1ps

module mhxy_post (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [mhxy_pkg::DEG_W-1:0]            offset,
   input  logic                                  up_valid,
   input  mhxy_pkg::cordic_data_type             up_data,
   output logic                                  up_ready,
   output logic                                  dn_valid,
   output logic signed [mhxy_pkg::HEAD_W-1:0]    dn_heading,
   input  logic                                  dn_stall
);

   logic                                 valid_ff;
   logic                                 valid_in;
   logic signed [mhxy_pkg::HEAD_W-1:0]   heading_ff;
   logic signed [mhxy_pkg::HEAD_W-1:0]   heading_in;
   logic signed [mhxy_pkg::ANGLE_W-1:0]  z_cur;
   logic [mhxy_pkg::ANGLE_W-1:0]         z_mag;
   logic [mhxy_pkg::WHOLE_W-1:0]         whole_mag;
   logic [mhxy_pkg::DEG_W-1:0]           wrapped;

   assign up_ready = !valid_ff || !dn_stall;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // truncate toward zero, wrap negatives by a full turn
   always_comb begin
      z_cur     = up_data.zero ? '0 : up_data.z;
      z_mag     = (z_cur < 0) ? mhxy_pkg::ANGLE_W'(-z_cur) : mhxy_pkg::ANGLE_W'(z_cur);
      whole_mag = z_mag[mhxy_pkg::ANGLE_W-1:mhxy_pkg::FRAC_BITS];
      if ((z_cur < 0) && (whole_mag != '0)) begin
         wrapped = mhxy_pkg::FULL_TURN - whole_mag[mhxy_pkg::DEG_W-1:0];
      end else begin
         wrapped = whole_mag[mhxy_pkg::DEG_W-1:0];
      end
      heading_in = $signed({1'b0, wrapped}) - $signed({1'b0, offset});
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         heading_ff <= heading_in;
      end
   end

   assign dn_valid   = valid_ff;
   assign dn_heading = heading_ff;

endmodule

### rtl/core/magnetic_heading_from_xy.sv
// Pipeline: fold cell, 16 cordic cells and output cell, each registered; results
// wait in the chain while the result side stalls.
// Throughput: one sample per cycle; every cell of the chain frees when its
// successor takes its data, so the rate is set by the result side alone.
// Reset: synchronous; empties the chain and sets heading_offset to 75.
`timescale 1ns / 1ps
`include "magnetic_heading_from_xy_defines.svh"

module magnetic_heading_from_xy (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [mhxy_pkg::IN_W-1:0]      req_x_comp,
   input  logic signed [mhxy_pkg::IN_W-1:0]      req_y_comp,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mhxy_pkg::HEAD_W-1:0]    rsp_heading_deg,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mhxy_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [mhxy_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [mhxy_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int N = mhxy_pkg::CORDIC_ITERS;

   logic [mhxy_pkg::DEG_W-1:0] offset_ff;
   logic [mhxy_pkg::DEG_W-1:0] offset_in;
   logic                       csr_wr;
   logic                       req_ready;

   logic                       chain_valid [N+1];
   logic                       chain_ready [N+2];
   mhxy_pkg::cordic_data_type  chain_data  [N+1];

   // register port, writes complete in the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == mhxy_pkg::REG_HEADING_OFFSET);
   assign offset_in  = csr_wr ? csr_pwdata[mhxy_pkg::DEG_W-1:0] : offset_ff;
   assign csr_prdata = (csr_paddr[2] == mhxy_pkg::REG_HEADING_OFFSET) ?
                       mhxy_pkg::CSR_DATA_W'(offset_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= mhxy_pkg::OFFSET_RESET;
      end else begin
         offset_ff <= offset_in;
      end
   end

   // fold cell
   assign req_stall = !req_ready;

   mhxy_prerot u_prerot (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_x     (req_x_comp),
      .up_y     (req_y_comp),
      .up_ready (req_ready),
      .dn_valid (chain_valid[0]),
      .dn_data  (chain_data[0]),
      .dn_ready (chain_ready[1])
   );

   // row of cordic cells
   for (genvar i = 0; i < N; i++) begin : g_cell
      mhxy_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_amt (mhxy_pkg::SHIFT_W'(i)),
         .up_valid  (chain_valid[i]),
         .up_data   (chain_data[i]),
         .up_ready  (chain_ready[i+1]),
         .dn_valid  (chain_valid[i+1]),
         .dn_data   (chain_data[i+1]),
         .dn_ready  (chain_ready[i+2])
      );
   end

   assign chain_ready[0] = req_ready;

   // output cell
   mhxy_post u_post (
      .clock      (clock),
      .reset      (reset),
      .offset     (offset_ff),
      .up_valid   (chain_valid[N]),
      .up_data    (chain_data[N]),
      .up_ready   (chain_ready[N+1]),
      .dn_valid   (rsp_valid),
      .dn_heading (rsp_heading_deg),
      .dn_stall   (rsp_stall)
   );

   // checks
   `MHXY_ASSERT_IMPL(a_stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall)
   `MHXY_ASSERT_IMPL(a_heading_range, clock, reset, rsp_valid, ($signed({rsp_heading_deg[mhxy_pkg::HEAD_W-1], rsp_heading_deg}) + $signed({2'b00, offset_ff})) >= 0 && ($signed({rsp_heading_deg[mhxy_pkg::HEAD_W-1], rsp_heading_deg}) + $signed({2'b00, offset_ff})) <= 360)
   `MHXY_ASSERT_NEXT(a_offset_reset, clock, 1'b0, reset, offset_ff == mhxy_pkg::OFFSET_RESET && !rsp_valid)

endmodule

### bench/heading_checker.sv
// transfer monitor, heading predictor and result comparison for the heading block
`timescale 1ns / 1ps

module heading_checker #(
   parameter logic [mhxy_pkg::CSR_ADDR_W-1:0] OFFSET_ADDR = '0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [mhxy_pkg::IN_W-1:0]      req_x_comp,
   input  logic signed [mhxy_pkg::IN_W-1:0]      req_y_comp,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [mhxy_pkg::HEAD_W-1:0]    rsp_heading_deg,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mhxy_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [mhxy_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   input  logic                                  csr_pready,
   output int                                    headings_owed,
   output int                                    heading_errors
);

   // headings still owed by the block, oldest first
   logic signed [mhxy_pkg::HEAD_W-1:0] owed_headings [$];
   logic [mhxy_pkg::DEG_W-1:0]         offset_copy;
   int                                 error_tally;

   // vectoring cordic on the sample, truncate, wrap, subtract the offset
   function automatic logic signed [mhxy_pkg::HEAD_W-1:0] predict_heading(
      input logic signed [mhxy_pkg::IN_W-1:0] x_in,
      input logic signed [mhxy_pkg::IN_W-1:0] y_in,
      input logic [mhxy_pkg::DEG_W-1:0]       offset
   );
      longint vx;
      longint vy;
      longint acc;
      longint step_x;
      longint step_y;
      longint whole;
      longint diff;
      int     i;
      vx  = x_in;
      vy  = y_in;
      acc = 0;
      if (vx != 0 || vy != 0) begin
         // left half plane: flip the vector, start from a half turn
         if (vx < 0) begin
            acc = (vy >= 0) ? longint'(mhxy_pkg::HALF_TURN_Q16)
                            : -longint'(mhxy_pkg::HALF_TURN_Q16);
            vx  = -vx;
            vy  = -vy;
         end
         vx = vx * 256;
         vy = vy * 256;
         for (i = 0; i < mhxy_pkg::CORDIC_ITERS && i < mhxy_pkg::TABLE_LEN; i++) begin
            step_x = vy >>> i;
            step_y = vx >>> i;
            if (vy >= 0) begin
               vx  = vx + step_x;
               vy  = vy - step_y;
               acc = acc + longint'(mhxy_pkg::ATAN_TABLE[i]);
            end else begin
               vx  = vx - step_x;
               vy  = vy + step_y;
               acc = acc - longint'(mhxy_pkg::ATAN_TABLE[i]);
            end
         end
      end
      // truncate toward zero to whole degrees
      if (acc >= 0)
         whole = acc >>> mhxy_pkg::FRAC_BITS;
      else
         whole = -((-acc) >>> mhxy_pkg::FRAC_BITS);
      if (whole < 0)
         whole = whole + 360;
      diff = whole - longint'(offset);
      return diff[mhxy_pkg::HEAD_W-1:0];
   endfunction

   // watch both channels and the register port at every rising edge
   always @(posedge clock) begin : watch
      logic signed [mhxy_pkg::HEAD_W-1:0] due;
      if (reset) begin
         offset_copy = mhxy_pkg::OFFSET_RESET;
         owed_headings.delete();
         error_tally = 0;
      end else begin
         // sample transfer: one heading becomes due
         if (req_valid && !req_stall)
            owed_headings.push_back(predict_heading(req_x_comp, req_y_comp, offset_copy));
         // result transfer: compare with the oldest due heading
         if (rsp_valid && !rsp_stall) begin
            if (owed_headings.size() == 0) begin
               error_tally++;
               $error("heading_deg: expected nothing, actual %0d", rsp_heading_deg);
            end else begin
               due = owed_headings.pop_front();
               if (rsp_heading_deg !== due) begin
                  error_tally++;
                  $error("heading_deg: expected %0d, actual %0d", due, rsp_heading_deg);
               end
            end
         end
         // offset register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == OFFSET_ADDR)
            offset_copy = csr_pwdata[mhxy_pkg::DEG_W-1:0];
      end
      headings_owed  <= owed_headings.size();
      heading_errors <= error_tally;
   end

endmodule

### bench/tb_top.sv
// stimulus, register writes, watchdog and verdict around the heading block
`timescale 1ns / 1ps

module tb_top;

   localparam int LATENCY       = 18;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_SAMPLES = 175;
   localparam int CORNER_COUNT  = 20;
   localparam logic [mhxy_pkg::CSR_ADDR_W-1:0] HEADING_OFFSET_ADDR =
      mhxy_pkg::CSR_ADDR_W'(4 * mhxy_pkg::REG_HEADING_OFFSET);

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic signed [mhxy_pkg::IN_W-1:0]      req_x_comp;
   logic signed [mhxy_pkg::IN_W-1:0]      req_y_comp;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic signed [mhxy_pkg::HEAD_W-1:0]    rsp_heading_deg;
   logic                                  csr_psel;
   logic                                  csr_penable;
   logic                                  csr_pwrite;
   logic [mhxy_pkg::CSR_ADDR_W-1:0]       csr_paddr;
   logic [mhxy_pkg::CSR_DATA_W-1:0]       csr_pwdata;
   logic [mhxy_pkg::CSR_DATA_W-1:0]       csr_prdata;
   logic                                  csr_pready;

   int headings_owed;
   int heading_errors;
   int sender_idle_pct;
   int stall_pct;
   int quiet_cycles = 0;

   // corner samples: zero vector, axes, extremes, half turn boundary
   logic signed [mhxy_pkg::IN_W-1:0] corner_x [CORNER_COUNT] = '{
      16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0,
      16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd1,
      -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd0,
      16'sd0, -16'sd5, -16'sd5, 16'sd10000, -16'sd10000
   };
   logic signed [mhxy_pkg::IN_W-1:0] corner_y [CORNER_COUNT] = '{
      16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768,
      16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd0,
      -16'sd1, 16'sd1, -16'sd1, 16'sd0, 16'sd1,
      -16'sd1, 16'sd0, -16'sd1, 16'sd10000, 16'sd10000
   };

   // offsets per phase; the entries of phases 5 and 6 are replaced by random values
   logic [mhxy_pkg::DEG_W-1:0] phase_offset [PHASE_COUNT] = '{
      9'd0, 9'd359, 9'd511, 9'd1, 9'd180, 9'd0, 9'd0, 9'd256
   };

   magnetic_heading_from_xy uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x_comp      (req_x_comp),
      .req_y_comp      (req_y_comp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_heading_deg (rsp_heading_deg),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   heading_checker #(.OFFSET_ADDR(HEADING_OFFSET_ADDR)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x_comp      (req_x_comp),
      .req_y_comp      (req_y_comp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_heading_deg (rsp_heading_deg),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .headings_owed   (headings_owed),
      .heading_errors  (heading_errors)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side stall
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   // offer one sample, with random idle cycles ahead of it; starts and ends at a falling edge
   task automatic send_sample(input logic signed [mhxy_pkg::IN_W-1:0] x_val,
                              input logic signed [mhxy_pkg::IN_W-1:0] y_val);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid  <= 1'b0;
         req_x_comp <= mhxy_pkg::IN_W'($urandom);
         req_y_comp <= mhxy_pkg::IN_W'($urandom);
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_x_comp <= x_val;
      req_y_comp <= y_val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // random sample, biased toward axes, diagonals, tiny vectors and extremes
   task automatic pick_sample(output logic signed [mhxy_pkg::IN_W-1:0] x_val,
                              output logic signed [mhxy_pkg::IN_W-1:0] y_val);
      int kind;
      logic signed [mhxy_pkg::IN_W-1:0] ends [6];
      ends = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
      kind = $urandom_range(0, 99);
      x_val = mhxy_pkg::IN_W'($urandom);
      y_val = mhxy_pkg::IN_W'($urandom);
      if (kind >= 55 && kind < 70) begin
         x_val = mhxy_pkg::IN_W'($signed($urandom_range(0, 8)) - 4);
         y_val = mhxy_pkg::IN_W'($signed($urandom_range(0, 8)) - 4);
      end else if (kind >= 70 && kind < 80) begin
         if ($urandom_range(0, 1))
            x_val = '0;
         else
            y_val = '0;
      end else if (kind >= 80 && kind < 90) begin
         y_val = $urandom_range(0, 1) ? x_val : -x_val;
      end else if (kind >= 90) begin
         x_val = ends[$urandom_range(0, 5)];
         y_val = ends[$urandom_range(0, 5)];
      end
   endtask

   // write the offset register; starts and ends at a falling edge
   task automatic write_offset(input logic [mhxy_pkg::DEG_W-1:0] offset);
      logic [mhxy_pkg::CSR_DATA_W-1:0] word;
      word = $urandom;
      word[mhxy_pkg::DEG_W-1:0] = offset;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= HEADING_OFFSET_ADDR;
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // hold samples back until every owed heading has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      wait (headings_owed == 0);
      @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   initial begin
      logic signed [mhxy_pkg::IN_W-1:0] x_val;
      logic signed [mhxy_pkg::IN_W-1:0] y_val;
      logic [mhxy_pkg::DEG_W-1:0]       offset;
      int                               mode;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_x_comp      = '0;
      req_y_comp      = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      sender_idle_pct = 0;
      stall_pct       = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corner samples at the reset offset
      for (int i = 0; i < CORNER_COUNT; i++)
         send_sample(corner_x[i], corner_y[i]);

      // random phases, each with its own offset and idle pattern
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         offset = phase_offset[phase];
         if (phase == 5 || phase == 6)
            offset = mhxy_pkg::DEG_W'($urandom_range(0, 511));
         write_offset(offset);
         mode = phase % 4;
         sender_idle_pct = (mode == 1) ? 64 : (mode == 3) ? 14 : 0;
         stall_pct       = (mode == 2) ? 64 : (mode == 3) ? 14 : 0;
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            pick_sample(x_val, y_val);
            send_sample(x_val, y_val);
         end
      end

      req_valid <= 1'b0;
      wait (headings_owed == 0);
      repeat (2 * LATENCY) @(posedge clock);
      if (heading_errors == 0 && headings_owed == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
